// File: rtl/core/ctc_pkg.sv
// Package for the cruise throttle controller: item and state types,
// step sizes, bands and register reset values. No dependencies.
package ctc_pkg;

    localparam int VEL_W  = 11;
    localparam int THR_W  = 8;
    localparam int TGT_W  = 7;
    localparam int ENG_W  = 10;
    localparam int DLT_W  = 13;

    // register map (index = paddr / 4)
    localparam logic REG_ENGAGE_VELOCITY = 1'b0;
    localparam logic REG_THROTTLE_MAX    = 1'b1;

    localparam logic [ENG_W-1:0] ENGAGE_RESET = 10'd200;
    localparam logic [THR_W-1:0] TMAX_RESET   = 8'd80;

    localparam logic [THR_W-1:0] STEP_SMALL  = 8'd1;
    localparam logic [THR_W-1:0] STEP_PEDAL  = 8'd5;
    localparam logic [THR_W-1:0] STEP_LARGE  = 8'd10;

    localparam logic signed [DLT_W-1:0] BAND_HI  = 13'sd20;
    localparam logic signed [DLT_W-1:0] BAND_MID = 13'sd10;
    localparam logic signed [DLT_W-1:0] BAND_LO  = 13'sd4;

    // v / 10 as (v * 205) >> 11, exact for 0 <= v <= 1023
    localparam logic [7:0] DIV10_MUL   = 8'd205;
    localparam int         DIV10_SHIFT = 11;

    typedef struct packed {
        logic                    cruise_button;
        logic                    brake_pressed;
        logic                    gas_pressed;
        logic                    top_gear_switch;
        logic                    engine_switch;
        logic signed [VEL_W-1:0] velocity;
    } in_item_t;

    typedef struct packed {
        logic [TGT_W-1:0] target;
        logic             cruise;
        logic [THR_W-1:0] throttle;
    } ctl_state_t;

    typedef struct packed {
        logic [THR_W-1:0] throttle_max;
        logic [ENG_W-1:0] engage_velocity;
    } cfg_t;

endpackage

// File: rtl/core/ctc_cfg_regs.sv
// APB register file for the cruise throttle controller.
// Depends on ctc_pkg for the register map and reset values.
module ctc_cfg_regs
    import ctc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [ENG_W-1:0] engage_reg;
    logic [THR_W-1:0] tmax_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            engage_reg <= ENGAGE_RESET;
            tmax_reg   <= TMAX_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_ENGAGE_VELOCITY: engage_reg <= pwdata[ENG_W-1:0];
                REG_THROTTLE_MAX:    tmax_reg   <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ENGAGE_VELOCITY: prdata = {{(32-ENG_W){1'b0}}, engage_reg};
            REG_THROTTLE_MAX:    prdata = {{(32-THR_W){1'b0}}, tmax_reg};
            default:             prdata = '0;
        endcase
    end

    assign cfg.engage_velocity = engage_reg;
    assign cfg.throttle_max    = tmax_reg;

endmodule

// File: rtl/core/ctc_step.sv
// Next-state logic for one control period: pedals, engage/disengage and
// cruise trim. Pure combinational. Depends on ctc_pkg.
module ctc_step
    import ctc_pkg::*;
(
    input  in_item_t   item,
    input  ctl_state_t cur,
    input  cfg_t       cfg,
    output ctl_state_t nxt,
    output logic       engine_on
);

    function automatic logic [THR_W-1:0] rise(input logic [THR_W-1:0] t,
                                              input logic [THR_W-1:0] step,
                                              input logic [THR_W-1:0] tmax);
        logic [THR_W:0] s;
        s = {1'b0, t} + {1'b0, step};
        return (s > {1'b0, tmax}) ? tmax : s[THR_W-1:0];
    endfunction

    function automatic logic [THR_W-1:0] fall(input logic [THR_W-1:0] t,
                                              input logic [THR_W-1:0] step);
        return (t <= step) ? '0 : t - step;
    endfunction

    logic                    vel_zero;
    logic                    engage_ok;
    logic [17:0]             div_prod;
    logic [TGT_W-1:0]        vel_div10;
    logic [THR_W-1:0]        thr_a;
    logic [THR_W-1:0]        thr_b;
    logic                    cru_c;
    logic [TGT_W-1:0]        tgt_c;
    logic                    cru_d;
    logic [TGT_W-1:0]        tgt_d;
    logic [DLT_W-1:0]        tgt_x10;
    logic signed [DLT_W-1:0] delta;
    logic [THR_W-1:0]        thr_e;

    assign vel_zero  = (item.velocity == '0);
    assign engine_on = item.engine_switch || !vel_zero;
    assign engage_ok = ($signed({item.velocity[VEL_W-1], item.velocity})
                        >= $signed({2'b00, cfg.engage_velocity}));
    assign div_prod  = item.velocity[9:0] * DIV10_MUL;
    assign vel_div10 = div_prod[DIV10_SHIFT +: TGT_W];

    always_comb
    begin
        thr_a = item.gas_pressed ? rise(cur.throttle, STEP_PEDAL, cfg.throttle_max)
                                 : cur.throttle;
        if (item.brake_pressed)
            thr_b = vel_zero ? '0 : fall(thr_a, STEP_PEDAL);
        else
            thr_b = thr_a;

        cru_c = cur.cruise;
        tgt_c = cur.target;
        if (engage_ok && item.cruise_button)
        begin
            if (!cur.cruise)
                tgt_c = vel_div10;
            cru_c = 1'b1;
        end

        if (item.gas_pressed || item.brake_pressed || !item.top_gear_switch)
        begin
            cru_d = 1'b0;
            tgt_d = '0;
        end
        else
        begin
            cru_d = cru_c;
            tgt_d = tgt_c;
        end
    end

    assign tgt_x10 = {3'b000, tgt_d, 3'b000} + {5'b00000, tgt_d, 1'b0};
    assign delta   = $signed({{(DLT_W-VEL_W){item.velocity[VEL_W-1]}}, item.velocity})
                     - $signed(tgt_x10);

    always_comb
    begin
        thr_e = thr_b;
        if (cru_d)
        begin
            if (delta >= BAND_HI)
                thr_e = fall(thr_b, STEP_LARGE);
            else if (delta >= BAND_MID)
                thr_e = fall(thr_b, STEP_PEDAL);
            else if (delta >= BAND_LO)
                thr_e = fall(thr_b, STEP_SMALL);
            else if (delta <= -BAND_HI)
                thr_e = rise(thr_b, STEP_LARGE, cfg.throttle_max);
            else if (delta <= -BAND_MID)
                thr_e = rise(thr_b, STEP_PEDAL, cfg.throttle_max);
            else if (delta <= -BAND_LO)
                thr_e = rise(thr_b, STEP_SMALL, cfg.throttle_max);
        end
    end

    // engine off: everything holds
    always_comb
    begin
        if (engine_on)
        begin
            nxt.throttle = thr_e;
            nxt.cruise   = cru_d;
            nxt.target   = tgt_d;
        end
        else
        begin
            nxt = cur;
        end
    end

endmodule

// File: rtl/core/cruise_throttle_controller_core.sv
// Cruise throttle controller: one item per control period in, one result out.
// Stream input register, single-pass control step, stream output register.
//
// Usage:
//   s_* carries one control period per item: measured velocity and the
//   driver switches. m_* returns one result per item: throttle command,
//   cruise flag, latched target (whole m/s) and the engine-running flag.
//   The APB port sets the engage velocity (0x0) and throttle ceiling (0x4);
//   write only while no item is in flight.
// Timing:
//   An accepted item is held in the input register; the control
//   step then runs and loads the throttle/cruise/target state and the
//   output register at the same edge, so a result reaches m_tvalid
//   through the input and output registers. One item per cycle is
//   sustained while m_tready stays high: the state loop is one
//   register deep, so each item sees the state left by the previous one.
// Reset: state, valids and config registers return to their defaults (throttle 0,
//   cruise off, target 0, engage 200, ceiling 80).
// Stall: while m_tready is low the output holds its result; the input
//   register still takes one more item, then s_tready drops.
module cruise_throttle_controller_core
    import ctc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [10:0] velocity, [11] engine_switch, [12] top_gear_switch,
    // [13] gas_pressed, [14] brake_pressed, [15] cruise_button
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] throttle_out, [8] cruise_on, [15:9] target_out,
    // [16] engine_on, [23:17] zero
    output logic [23:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t       cfg;
    in_item_t   in_item_reg;
    logic       in_valid_reg;
    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       engine_next;
    logic       out_valid_reg;
    logic [23:0] out_data_reg;
    logic       fire;

    ctc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ctc_step u_step (
        .item      (in_item_reg),
        .cur       (state_reg),
        .cfg       (cfg),
        .nxt       (state_next),
        .engine_on (engine_next)
    );

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (fire)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_item_reg <= in_item_t'(s_tdata);
        if (fire)
            out_data_reg <= {7'b0, engine_next, state_next.target,
                             state_next.cruise, state_next.throttle};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
